// ===== rtl/rmq_pkg.sv =====
// Shared constants, item record and branch codes for the rotation matrix to
// quaternion pipeline. No dependencies.
package rmq_pkg;

    localparam int FRAC_BITS = 30;
    localparam int IN_W      = 32;                      // matrix entry width
    localparam int OUT_W     = 32;                      // quaternion component width
    localparam int THR_W     = 31;                      // trace threshold width
    localparam int RAD_W     = IN_W + 3;                // signed radicand / trace
    localparam int NUM_W     = IN_W + 1;                // signed numerator
    localparam int MAG_W     = NUM_W;                   // numerator magnitude
    localparam int SQ_RAW    = RAD_W - 1 + FRAC_BITS;
    localparam int SQ_W      = SQ_RAW + (SQ_RAW % 2);   // square root operand, even
    localparam int ROOT_W    = SQ_W / 2;                // root bits, one per stage
    localparam int SREM_W    = ROOT_W + 3;              // root remainder
    localparam int DEN_W     = ROOT_W + 1;              // divisor 2r
    localparam int DREM_W    = DEN_W + 1;               // divide remainder
    localparam int DNUM_W    = MAG_W + FRAC_BITS;       // dividend |num| << FRAC_BITS
    localparam int QW        = OUT_W;                   // quotient bits, one per stage
    localparam int HI_W      = DNUM_W - QW;             // dividend bits above quotient

    // Dominant component
    localparam logic [1:0] DOM_X = 2'd0;
    localparam logic [1:0] DOM_Y = 2'd1;
    localparam logic [1:0] DOM_Z = 2'd2;
    localparam logic [1:0] DOM_W = 2'd3;

    typedef struct packed {
        logic [1:0]                  dom;
        logic [2:0]                  neg;
        logic [2:0][MAG_W-1:0]       mag;
        logic [SQ_W-1:0]             sq_n;
        logic [SREM_W-1:0]           sq_rem;
        logic [ROOT_W-1:0]           root;
        logic [2:0][QW-1:0]          dv_n;
        logic [2:0][DREM_W-1:0]      dv_rem;
        logic [2:0][QW-1:0]          quo;
        logic [2:0]                  ovf;
    } rmq_item_t;

endpackage

// ===== rtl/rmq_front.sv =====
// Front end: trace, branch selection, radicand and numerators (two stages).
// Depends on rmq_pkg.
module rmq_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          ce,
    input  logic                          in_valid,
    input  logic [9*rmq_pkg::IN_W-1:0]    in_data,
    input  logic [rmq_pkg::THR_W-1:0]     thr,
    output logic                          out_valid,
    output rmq_pkg::rmq_item_t            out_item
);
    import rmq_pkg::*;

    logic signed [RAD_W-1:0] m [0:8];
    logic signed [RAD_W-1:0] one_c;
    logic signed [RAD_W-1:0] tr;
    logic [1:0]              dom_next;
    logic signed [RAD_W-1:0] rad_next;
    logic signed [NUM_W-1:0] n_next [0:2];
    logic signed [NUM_W-1:0] a1, a3, a2, a6, a5, a7;

    logic                    va_reg;
    logic [1:0]              dom_reg;
    logic signed [RAD_W-1:0] rad_reg;
    logic signed [NUM_W-1:0] n_reg [0:2];

    logic                    vb_reg;
    rmq_item_t               item_next, item_reg;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            m[i] = RAD_W'($signed(in_data[i*IN_W +: IN_W]));
        end
        one_c = RAD_W'(1) <<< FRAC_BITS;
        tr    = m[0] + m[4] + m[8];
        a1 = NUM_W'($signed(in_data[1*IN_W +: IN_W]));
        a2 = NUM_W'($signed(in_data[2*IN_W +: IN_W]));
        a3 = NUM_W'($signed(in_data[3*IN_W +: IN_W]));
        a5 = NUM_W'($signed(in_data[5*IN_W +: IN_W]));
        a6 = NUM_W'($signed(in_data[6*IN_W +: IN_W]));
        a7 = NUM_W'($signed(in_data[7*IN_W +: IN_W]));
        if (tr > $signed({{(RAD_W-THR_W){1'b0}}, thr})) begin
            dom_next = DOM_W;
            rad_next = one_c + tr;
            n_next[0] = a7 - a5; n_next[1] = a2 - a6; n_next[2] = a3 - a1;
        end else if (m[0] > m[4] && m[0] > m[8]) begin
            dom_next = DOM_X;
            rad_next = one_c + m[0] - m[4] - m[8];
            n_next[0] = a1 + a3; n_next[1] = a2 + a6; n_next[2] = a7 - a5;
        end else if (m[4] > m[8]) begin
            dom_next = DOM_Y;
            rad_next = one_c + m[4] - m[0] - m[8];
            n_next[0] = a1 + a3; n_next[1] = a5 + a7; n_next[2] = a2 - a6;
        end else begin
            dom_next = DOM_Z;
            rad_next = one_c + m[8] - m[0] - m[4];
            n_next[0] = a2 + a6; n_next[1] = a5 + a7; n_next[2] = a3 - a1;
        end
    end

    always_comb begin
        item_next        = '0;
        item_next.dom    = dom_reg;
        item_next.sq_n   = (rad_reg > 0) ?
                           (SQ_W'(unsigned'(rad_reg)) << FRAC_BITS) : '0;
        for (int i = 0; i < 3; i++) begin
            item_next.neg[i] = n_reg[i][NUM_W-1];
            item_next.mag[i] = n_reg[i][NUM_W-1] ? MAG_W'(-n_reg[i]) : MAG_W'(n_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else if (ce) begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
        if (ce) begin
            dom_reg  <= dom_next;
            rad_reg  <= rad_next;
            n_reg    <= n_next;
            item_reg <= item_next;
        end
    end

    assign out_valid = vb_reg;
    assign out_item  = item_reg;

endmodule

// ===== rtl/rmq_sqrt_stage.sv =====
// One stage of the digit-by-digit square root: one root bit per stage.
// Depends on rmq_pkg.
module rmq_sqrt_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                ce,
    input  logic                in_valid,
    input  rmq_pkg::rmq_item_t  in_item,
    output logic                out_valid,
    output rmq_pkg::rmq_item_t  out_item
);
    import rmq_pkg::*;

    logic [SREM_W-1:0] rem2;
    logic [SREM_W-1:0] trial;
    rmq_item_t         item_next, item_reg;
    logic              valid_reg;

    always_comb begin
        item_next = in_item;
        rem2  = {in_item.sq_rem[SREM_W-3:0], in_item.sq_n[SQ_W-1 -: 2]};
        trial = SREM_W'({in_item.root, 2'b01});
        item_next.sq_n = in_item.sq_n << 2;
        if (rem2 >= trial) begin
            item_next.sq_rem = rem2 - trial;
            item_next.root   = {in_item.root[ROOT_W-2:0], 1'b1};
        end else begin
            item_next.sq_rem = rem2;
            item_next.root   = {in_item.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ce) begin
            valid_reg <= in_valid;
        end
        if (ce) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== rtl/rmq_div_stage.sv =====
// One restoring division stage for the three minor components: one quotient
// bit per lane per stage, divisor 2r. Depends on rmq_pkg.
module rmq_div_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                ce,
    input  logic                in_valid,
    input  rmq_pkg::rmq_item_t  in_item,
    output logic                out_valid,
    output rmq_pkg::rmq_item_t  out_item
);
    import rmq_pkg::*;

    logic [DREM_W-1:0] den;
    logic [DREM_W-1:0] rem2;
    rmq_item_t         item_next, item_reg;
    logic              valid_reg;

    always_comb begin
        item_next = in_item;
        den       = DREM_W'({in_item.root, 1'b0});
        rem2      = '0;
        for (int i = 0; i < 3; i++) begin
            rem2 = {in_item.dv_rem[i][DREM_W-2:0], in_item.dv_n[i][QW-1]};
            item_next.dv_n[i] = in_item.dv_n[i] << 1;
            if (rem2 >= den) begin
                item_next.dv_rem[i] = rem2 - den;
                item_next.quo[i]    = {in_item.quo[i][QW-2:0], 1'b1};
            end else begin
                item_next.dv_rem[i] = rem2;
                item_next.quo[i]    = {in_item.quo[i][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ce) begin
            valid_reg <= in_valid;
        end
        if (ce) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== rtl/rotation_matrix_to_quaternion.sv =====
// Top level of the rotation matrix to quaternion converter.
// Depends on rmq_pkg, rmq_front, rmq_sqrt_stage and rmq_div_stage.
//
// Usage
//   s_tdata carries one 3x3 rotation matrix, row-major, nine signed Q30
//   entries; m_tdata returns the unit quaternion (x, y, z, w), signed Q30,
//   saturated. cfg_we/cfg_wdata write the trace threshold (Q30, unsigned);
//   write it only while the pipeline is empty.
//   The pipeline is 2 front stages (trace, branch, radicand), 32 square
//   root stages (one root bit each), 1 divide setup stage, 32 divide stages
//   (one quotient bit each, three lanes side by side) and the output register.
//   Throughput is one item per cycle unless the receiver stalls; the
//   bit-per-stage root and divide chains set the depth.
//   Reset clears every valid bit and the threshold to zero.
//   All stages share one advance enable: the pipe moves whenever the output
//   register is empty or being taken. When the receiver stalls with a result
//   waiting, every stage holds its item and s_tready drops; nothing is lost
//   or repeated. Bubbles are not squeezed out; they travel with the items.
module rotation_matrix_to_quaternion (
    input  logic                          aclk,
    input  logic                          aresetn,
    // trace_threshold register
    input  logic                          cfg_we,
    input  logic [rmq_pkg::THR_W-1:0]     cfg_wdata,
    // matrix items: m00,m01,m02,m10,m11,m12,m20,m21,m22 from bit 0 up
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [9*rmq_pkg::IN_W-1:0]    s_tdata,
    // quaternion items: qx,qy,qz,qw from bit 0 up
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [4*rmq_pkg::OUT_W-1:0]   m_tdata
);
    import rmq_pkg::*;

    logic [THR_W-1:0] thr_reg;
    logic             ce;

    logic             sq_vld  [0:ROOT_W];
    rmq_item_t        sq_item [0:ROOT_W];
    logic             dv_vld  [0:QW];
    rmq_item_t        dv_item [0:QW];

    rmq_item_t        setup_next;
    logic             setup_vld_reg;
    rmq_item_t        setup_reg;

    logic [OUT_W-1:0] minor [0:2];
    logic [OUT_W-1:0] major;
    logic [4*OUT_W-1:0] out_next, out_reg;
    logic             out_vld_reg;
    rmq_item_t        fin;

    // advance everything when the output is free or being taken
    assign ce       = !out_vld_reg || m_tready;
    assign s_tready = ce;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= '0;
        end else if (cfg_we) begin
            thr_reg <= cfg_wdata;
        end
    end

    rmq_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (s_tvalid),
        .in_data   (s_tdata),
        .thr       (thr_reg),
        .out_valid (sq_vld[0]),
        .out_item  (sq_item[0])
    );

    for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
        rmq_sqrt_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ce        (ce),
            .in_valid  (sq_vld[k]),
            .in_item   (sq_item[k]),
            .out_valid (sq_vld[k+1]),
            .out_item  (sq_item[k+1])
        );
    end

    // divide setup: dividend |num| << FRAC_BITS, flag quotients past QW bits
    always_comb begin
        logic [DNUM_W-1:0] num;
        setup_next = sq_item[ROOT_W];
        num        = '0;
        for (int i = 0; i < 3; i++) begin
            num = DNUM_W'(sq_item[ROOT_W].mag[i]) << FRAC_BITS;
            setup_next.ovf[i]    = DREM_W'(num[DNUM_W-1 -: HI_W]) >=
                                   DREM_W'({sq_item[ROOT_W].root, 1'b0});
            setup_next.dv_rem[i] = DREM_W'(num[DNUM_W-1 -: HI_W]);
            setup_next.dv_n[i]   = num[QW-1:0];
            setup_next.quo[i]    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setup_vld_reg <= 1'b0;
        end else if (ce) begin
            setup_vld_reg <= sq_vld[ROOT_W];
        end
        if (ce) begin
            setup_reg <= setup_next;
        end
    end

    assign dv_vld[0]  = setup_vld_reg;
    assign dv_item[0] = setup_reg;

    for (genvar k = 0; k < QW; k++) begin : g_div
        rmq_div_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ce        (ce),
            .in_valid  (dv_vld[k]),
            .in_item   (dv_item[k]),
            .out_valid (dv_vld[k+1]),
            .out_item  (dv_item[k+1])
        );
    end

    // saturate, apply signs, zero the minors on a zero root, place the dominant component
    always_comb begin
        fin   = dv_item[QW];
        major = OUT_W'(fin.root >> 1);
        for (int i = 0; i < 3; i++) begin
            if (fin.root == '0) begin
                minor[i] = '0;
            end else if (fin.neg[i]) begin
                minor[i] = (fin.ovf[i] || fin.quo[i][QW-1]) ?
                           {1'b1, {(OUT_W-1){1'b0}}} : OUT_W'(-fin.quo[i]);
            end else begin
                minor[i] = (fin.ovf[i] || fin.quo[i][QW-1]) ?
                           {1'b0, {(OUT_W-1){1'b1}}} : fin.quo[i];
            end
        end
        unique case (fin.dom)
            DOM_X:   out_next = {minor[2], minor[1], minor[0], major};
            DOM_Y:   out_next = {minor[2], minor[1], major, minor[0]};
            DOM_Z:   out_next = {minor[2], major, minor[1], minor[0]};
            default: out_next = {major, minor[2], minor[1], minor[0]};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (ce) begin
            out_vld_reg <= dv_vld[QW];
        end
        if (ce) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;

endmodule
